// ===== src/vnf_pkg.sv =====
`default_nettype none
package vnf_pkg;

    localparam int NOISE_BITS = 24;
    localparam int RECIP_BITS = 31;
    localparam int RECIP_SHIFT = 30;
    localparam int OCT_CNT_BITS = 4;
    localparam int RECIP_DEPTH = 8;

    localparam logic [31:0] HASH_MUL_X = 32'd374761393;
    localparam logic [31:0] HASH_MUL_Z = 32'd668265263;
    localparam logic [31:0] HASH_MUL_MIX = 32'd1274126177;

    localparam logic [NOISE_BITS-1:0] OUT_MAX = 24'hFFFFFF;
    localparam logic [OCT_CNT_BITS-1:0] OCT_RESET = 4'd4;

    // round(2^30 * 2^(k-1) / (2^k - 1)) for octave count k = 1..8
    localparam logic [RECIP_BITS-1:0] RECIP_Q30 [RECIP_DEPTH] = '{
        31'd1073741824, 31'd715827883, 31'd613566757, 31'd572662306,
        31'd554189329, 31'd545392673, 31'd541098242, 31'd538976288
    };

endpackage
`default_nettype wire

// ===== src/vnf_octave.sv =====
`default_nettype none
module vnf_octave #(
    parameter int FRAC_BITS = 16,
    parameter int OCT = 0
) (
    input  wire logic                             i_clk,
    input  wire logic [4:0]                       i_en,
    input  wire logic signed [31:0]               i_x_coord,
    input  wire logic signed [31:0]               i_z_coord,
    output logic [vnf_pkg::NOISE_BITS-1:0]        o_octave
);
    localparam int F = FRAC_BITS;
    localparam int NB = vnf_pkg::NOISE_BITS;
    localparam int F2W = 2 * F;
    localparam int UPW = 2 * F + 2;
    localparam int LW = NB + F + 1;
    localparam logic [F+1:0] THREE = (F+2)'(3) << F;
    localparam logic [F:0] ONE = (F+1)'(1) << F;

    // stage 0: split, base hash products, fraction squares
    logic [63:0] w_sx, w_sz;
    logic [31:0] w_xi, w_zi;
    logic [F-1:0] w_xf, w_zf;
    logic [31:0] r_xa, r_zb;
    logic [F2W-1:0] r_xf2, r_zf2;
    logic [F-1:0] r_xf, r_zf;

    assign w_sx = {{32{i_x_coord[31]}}, i_x_coord} << OCT;
    assign w_sz = {{32{i_z_coord[31]}}, i_z_coord} << OCT;
    assign w_xi = w_sx[F+31:F];
    assign w_zi = w_sz[F+31:F];
    assign w_xf = w_sx[F-1:0];
    assign w_zf = w_sz[F-1:0];

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_xa  <= w_xi * vnf_pkg::HASH_MUL_X;
            r_zb  <= w_zi * vnf_pkg::HASH_MUL_Z;
            r_xf2 <= F2W'(w_xf) * F2W'(w_xf);
            r_zf2 <= F2W'(w_zf) * F2W'(w_zf);
            r_xf  <= w_xf;
            r_zf  <= w_zf;
        end
    end

    // stage 1: corner sums and first xor-shift; corners a b c d = (0,0) (1,0) (0,1) (1,1)
    logic [31:0] n_h [4];
    logic [31:0] r_h [4];
    logic [F-1:0] r_xs, r_zs;
    logic [F+1:0] r_xt, r_zt;

    always_comb begin
        logic [31:0] s;
        for (int j = 0; j < 4; j++) begin
            s = r_xa + r_zb + ((j % 2 == 1) ? vnf_pkg::HASH_MUL_X : 32'd0)
                + ((j / 2 == 1) ? vnf_pkg::HASH_MUL_Z : 32'd0);
            n_h[j] = s ^ (s >> 13);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_h  <= n_h;
            r_xs <= r_xf2[F2W-1:F];
            r_zs <= r_zf2[F2W-1:F];
            r_xt <= THREE - {1'b0, r_xf, 1'b0};
            r_zt <= THREE - {1'b0, r_zf, 1'b0};
        end
    end

    // stage 2: mixing multiply, smoothstep weights
    logic [31:0] r_hm [4];
    logic [UPW-1:0] w_up, w_vp;
    logic [F:0] r_u, r_v;

    assign w_up = UPW'(r_xs) * UPW'(r_xt);
    assign w_vp = UPW'(r_zs) * UPW'(r_zt);

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            for (int j = 0; j < 4; j++) begin
                r_hm[j] <= r_h[j] * vnf_pkg::HASH_MUL_MIX;
            end
            r_u <= w_up[2*F:F];
            r_v <= w_vp[2*F:F];
        end
    end

    // stage 3: corner values, blend along x
    logic [NB-1:0] w_c [4];
    logic [LW-1:0] w_l0, w_l1;
    logic [NB-1:0] r_row0, r_row1;
    logic [F:0] r_v3;

    always_comb begin
        for (int j = 0; j < 4; j++) begin
            w_c[j] = NB'((r_hm[j] ^ (r_hm[j] >> 16)) >> 8);
        end
    end

    assign w_l0 = LW'(w_c[0]) * LW'(ONE - r_u) + LW'(w_c[1]) * LW'(r_u);
    assign w_l1 = LW'(w_c[2]) * LW'(ONE - r_u) + LW'(w_c[3]) * LW'(r_u);

    always_ff @(posedge i_clk) begin
        if (i_en[3]) begin
            r_row0 <= w_l0[F+NB-1:F];
            r_row1 <= w_l1[F+NB-1:F];
            r_v3   <= r_v;
        end
    end

    // stage 4: blend along z
    logic [LW-1:0] w_lz;
    logic [NB-1:0] r_oct;

    assign w_lz = LW'(r_row0) * LW'(ONE - r_v3) + LW'(r_row1) * LW'(r_v3);

    always_ff @(posedge i_clk) begin
        if (i_en[4]) begin
            r_oct <= w_lz[F+NB-1:F];
        end
    end

    assign o_octave = r_oct;

endmodule
`default_nettype wire

// ===== src/vnf_norm.sv =====
`default_nettype none
module vnf_norm #(
    parameter int MAX_OCTAVES = 8
) (
    input  wire logic                                          i_clk,
    input  wire logic [2:0]                                    i_en,
    input  wire logic [vnf_pkg::OCT_CNT_BITS-1:0]              i_oct_cnt,
    input  wire logic [MAX_OCTAVES-1:0][vnf_pkg::NOISE_BITS-1:0] i_octave,
    output logic [vnf_pkg::NOISE_BITS-1:0]                     o_noise_value
);
    localparam int NB = vnf_pkg::NOISE_BITS;
    localparam int ACCW = NB + MAX_OCTAVES;
    localparam int PW = ACCW + vnf_pkg::RECIP_BITS;
    localparam int SH = vnf_pkg::RECIP_SHIFT + MAX_OCTAVES - 1;
    localparam int RW = PW - SH;

    // stage 5: weighted octave sum
    logic [ACCW-1:0] n_acc, r_acc;

    always_comb begin
        n_acc = '0;
        for (int i = 0; i < MAX_OCTAVES; i++) begin
            if (vnf_pkg::OCT_CNT_BITS'(i) < i_oct_cnt) begin
                n_acc = n_acc + (ACCW'(i_octave[i]) << (MAX_OCTAVES - 1 - i));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_acc <= n_acc;
        end
    end

    // stage 6: scale by reciprocal of the amplitude sum
    logic [2:0] w_ridx;
    logic [PW-1:0] r_prod;

    assign w_ridx = 3'(i_oct_cnt - vnf_pkg::OCT_CNT_BITS'(1));

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_prod <= PW'(r_acc) * PW'(vnf_pkg::RECIP_Q30[w_ridx]);
        end
    end

    // stage 7: shift down and saturate
    logic [RW-1:0] w_res;
    logic [NB-1:0] r_out;

    assign w_res = r_prod[PW-1:SH];

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            if (w_res > RW'(vnf_pkg::OUT_MAX)) begin
                r_out <= vnf_pkg::OUT_MAX;
            end else begin
                r_out <= w_res[NB-1:0];
            end
        end
    end

    assign o_noise_value = r_out;

endmodule
`default_nettype wire

// ===== src/value_noise_fbm.sv =====
// Eight register stages lie between an input transfer and the result showing
// on the output; the first is loaded at the transfer edge.
// Throughput: one item per cycle unless the output stalls; every octave has its
// own lane of hash and blend multipliers, so nothing is shared between items.
// Each stage holds only while it is full and the stage after it stalls.
// Reset (synchronous, active low) empties the pipeline and sets octaves to 4.
`default_nettype none
module value_noise_fbm #(
    parameter int MAX_OCTAVES = 8,
    parameter int FRAC_BITS = 16
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_we,
    input  wire logic [vnf_pkg::OCT_CNT_BITS-1:0]    i_cfg_data,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_ready,
    input  wire logic signed [31:0]                  i_x_coord,
    input  wire logic signed [31:0]                  i_z_coord,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_ready,
    output logic [vnf_pkg::NOISE_BITS-1:0]           o_noise_value
);
    localparam int STAGES = 8;
    localparam int CW = vnf_pkg::OCT_CNT_BITS;

    logic [STAGES-1:0] r_v;
    logic [STAGES-1:0] w_en;
    logic [CW-1:0] r_octaves;
    logic [CW-1:0] w_k;

    always_comb begin
        w_en[STAGES-1] = !r_v[STAGES-1] || i_out_ready;
        for (int s = STAGES - 2; s >= 0; s--) begin
            w_en[s] = !r_v[s] || w_en[s+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_en[0]) begin
                r_v[0] <= i_in_valid;
            end
            for (int s = 1; s < STAGES; s++) begin
                if (w_en[s]) begin
                    r_v[s] <= r_v[s-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_octaves <= vnf_pkg::OCT_RESET;
        end else if (i_cfg_we) begin
            r_octaves <= i_cfg_data;
        end
    end

    always_comb begin
        if (r_octaves == '0) begin
            w_k = CW'(1);
        end else if (r_octaves > CW'(MAX_OCTAVES)) begin
            w_k = CW'(MAX_OCTAVES);
        end else begin
            w_k = r_octaves;
        end
    end

    logic [MAX_OCTAVES-1:0][vnf_pkg::NOISE_BITS-1:0] w_oct;

    for (genvar g = 0; g < MAX_OCTAVES; g++) begin : g_lane
        vnf_octave #(
            .FRAC_BITS(FRAC_BITS),
            .OCT(g)
        ) u_octave (
            .i_clk    (i_clk),
            .i_en     (w_en[4:0]),
            .i_x_coord(i_x_coord),
            .i_z_coord(i_z_coord),
            .o_octave (w_oct[g])
        );
    end

    vnf_norm #(
        .MAX_OCTAVES(MAX_OCTAVES)
    ) u_norm (
        .i_clk        (i_clk),
        .i_en         (w_en[7:5]),
        .i_oct_cnt    (w_k),
        .i_octave     (w_oct),
        .o_noise_value(o_noise_value)
    );

    assign o_in_ready  = w_en[0];
    assign o_out_valid = r_v[STAGES-1];

`ifndef SYNTHESIS
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with empty output stage");

    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> r_v[0])
        else $error("transfer did not enter first stage");

    a_oct_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_k != '0) && (w_k <= CW'(MAX_OCTAVES)))
        else $error("octave count out of range");

    a_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[STAGES-2] && w_en[STAGES-1]) |=> o_out_valid)
        else $error("item lost before output stage");
`endif

endmodule
`default_nettype wire

// ===== tb/sv/value_noise_fbm_test.sv =====
`default_nettype none
module value_noise_fbm_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_OCT = 8;
    localparam int FB = 16;
    localparam int LATENCY = 8;
    localparam longint CYCLE_LIMIT = 400000;

    // ---------------------------------------------------------------
    // Noise predictor and pending-result store
    // ---------------------------------------------------------------
    class noise_scoreboard;
        logic [3:0] octaves;
        logic [23:0] pending[$];
        int errors;

        function new();
            octaves = vnf_pkg::OCT_RESET;
            errors = 0;
        endfunction

        static function logic [31:0] lattice_hash(logic [31:0] xi, logic [31:0] zi);
            logic [31:0] h;
            h = xi * vnf_pkg::HASH_MUL_X + zi * vnf_pkg::HASH_MUL_Z;
            h = h ^ (h >> 13);
            h = h * vnf_pkg::HASH_MUL_MIX;
            h = h ^ (h >> 16);
            return h >> 8;
        endfunction

        static function logic [63:0] fade(logic [63:0] f);
            logic [63:0] f2;
            f2 = (f * f) >> FB;
            return (f2 * ((64'd3 << FB) - 2 * f)) >> FB;
        endfunction

        static function logic [63:0] blend(logic [63:0] p, logic [63:0] q, logic [63:0] w);
            return (p * ((64'd1 << FB) - w) + q * w) >> FB;
        endfunction

        static function logic [63:0] octave_noise(logic signed [63:0] sx,
                                                  logic signed [63:0] sz);
            logic signed [63:0] qx, qz;
            logic [31:0] xi, zi;
            logic [63:0] u, v, a, b, c, d;
            qx = sx >>> FB;
            qz = sz >>> FB;
            xi = qx[31:0];
            zi = qz[31:0];
            u = fade({48'd0, sx[FB-1:0]});
            v = fade({48'd0, sz[FB-1:0]});
            a = lattice_hash(xi, zi);
            b = lattice_hash(xi + 1, zi);
            c = lattice_hash(xi, zi + 1);
            d = lattice_hash(xi + 1, zi + 1);
            return blend(blend(a, b, u), blend(c, d, u), v);
        endfunction

        function logic [23:0] fbm(logic signed [31:0] x, logic signed [31:0] z);
            int k;
            logic [63:0] acc, res;
            logic signed [63:0] xs, zs;
            k = octaves;
            if (k < 1) k = 1;
            if (k > MAX_OCT) k = MAX_OCT;
            acc = 0;
            for (int i = 0; i < k; i++) begin
                xs = 64'(x) <<< i;
                zs = 64'(z) <<< i;
                acc += octave_noise(xs, zs) << (MAX_OCT - 1 - i);
            end
            res = (acc * 64'(vnf_pkg::RECIP_Q30[k-1])) >> (30 + MAX_OCT - 1);
            if (res > 64'(vnf_pkg::OUT_MAX)) res = 64'(vnf_pkg::OUT_MAX);
            return res[23:0];
        endfunction

        function void note_input(logic signed [31:0] x, logic signed [31:0] z);
            pending.push_back(fbm(x, z));
        endfunction

        function void check_result(logic [23:0] got);
            logic [23:0] exp_val;
            if (pending.size() == 0) begin
                $display("%0t: unexpected noise_value %h", $time, got);
                errors++;
            end else begin
                exp_val = pending.pop_front();
                if (got !== exp_val) begin
                    $display("%0t: noise_value expected %h actual %h", $time, exp_val, got);
                    errors++;
                end
            end
        endfunction
    endclass

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic i_cfg_we = 0;
    logic [vnf_pkg::OCT_CNT_BITS-1:0] i_cfg_data = '0;
    logic i_in_valid = 0;
    logic o_in_ready;
    logic signed [31:0] i_x_coord = '0;
    logic signed [31:0] i_z_coord = '0;
    logic o_out_valid;
    logic i_out_ready = 0;
    logic [vnf_pkg::NOISE_BITS-1:0] o_noise_value;

    noise_scoreboard sb = new();
    longint cycles = 0;
    bit hold_output = 0;
    bit long_hold_req = 0;

    always #1 i_clk = ~i_clk;

    value_noise_fbm dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready),
        .i_x_coord(i_x_coord), .i_z_coord(i_z_coord),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .o_noise_value(o_noise_value)
    );

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("value_noise_fbm_test: FAIL");
            $finish;
        end
    end

    // monitors
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && o_in_ready) sb.note_input(i_x_coord, i_z_coord);
        if (i_rst_n && o_out_valid && i_out_ready) sb.check_result(o_noise_value);
    end

    // receiver: random stalls, plus one long hold-off on request
    initial begin
        int gap;
        @(posedge i_rst_n);
        forever begin
            if (long_hold_req) begin
                i_out_ready <= 0;
                repeat (200) @(posedge i_clk);
                long_hold_req = 0;
            end
            gap = hold_output ? 0 : $urandom_range(0, 14);
            if ($urandom_range(0, 3) == 0) gap = 0;
            if (gap > 0) begin
                i_out_ready <= 0;
                repeat (gap) @(posedge i_clk);
            end
            i_out_ready <= 1;
            @(posedge i_clk);
        end
    end

    bit no_gaps;

    task automatic send(logic signed [31:0] x, logic signed [31:0] z);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            i_in_valid <= 0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1;
        i_x_coord <= x;
        i_z_coord <= z;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic drain();
        i_in_valid <= 0;
        // let the monitor log the last transfer before counting what is pending
        @(posedge i_clk);
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    task automatic set_octaves(logic [3:0] v);
        drain();
        i_cfg_we <= 1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we <= 0;
        sb.octaves = v;
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 3))
            0: return $urandom();
            1: return 32'($signed($urandom_range(0, 2000)) - 1000) <<< 16
                      | 32'($urandom_range(0, 65535));
            2: return {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 16'($urandom())};
            default: return 32'($signed($urandom_range(0, 200000)) - 100000);
        endcase
    endfunction

    initial begin
        logic [31:0] edges[8] = '{32'h0, 32'hFFFFFFFF, 32'h7FFFFFFF, 32'h80000000,
                                  32'h0000FFFF, 32'h00010000, 32'hFFFF0000, 32'h00008000};
        logic [3:0] settings[$] = '{4'd1, 4'd8, 4'd0, 4'd15, 4'd2, 4'd5, 4'd9, 4'd3, 4'd7};
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: field extremes at reset octave count
        for (int i = 0; i < 8; i++) send(edges[i], edges[(i * 3 + 1) % 8]);
        send(32'h12345678, 32'hEDCBA987);
        send(32'hAAAAAAAA, 32'h55555555);

        // backpressure: long output stall while inputs keep coming
        long_hold_req = 1;
        no_gaps = 1;
        for (int i = 0; i < 40; i++) send(rand_coord(), rand_coord());
        no_gaps = 0;

        // pause until all results are back
        drain();

        foreach (settings[s]) begin
            set_octaves(settings[s]);
            send(32'h7FFFFFFF, 32'h80000000);
            send(32'hFFFFFFFF, 32'h0);
            for (int i = 0; i < 100; i++) send(rand_coord(), rand_coord());
        end
        set_octaves(4'd4);
        hold_output = 1;
        no_gaps = 1;
        for (int i = 0; i < 50; i++) send(rand_coord(), rand_coord());

        drain();
        if (sb.errors == 0) begin
            $display("value_noise_fbm_test: PASS");
        end else begin
            $display("value_noise_fbm_test: FAIL");
        end
        $finish;
    end
endmodule
`default_nettype wire

// ===== value_noise_fbm.f =====
src/vnf_pkg.sv
src/vnf_octave.sv
src/vnf_norm.sv
src/value_noise_fbm.sv
tb/sv/value_noise_fbm_test.sv
